FILE: rtl/core/radix_digit_converter_unit_assert.svh
// Assertion macros shared by the digit converter RTL.
`ifndef RADIX_DIGIT_CONVERTER_UNIT_ASSERT_SVH
`define RADIX_DIGIT_CONVERTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low.
`define RDC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is low.
`define RDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RDC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define RDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/core/rdc_pkg.sv
`timescale 1ns / 1ps

package rdc_pkg;

    localparam int NUMBER_W    = 64;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int RADIX_REG_W = 5;
    localparam int CHAR_W      = 8;
    localparam int ALPHA_BITS  = 128;
    localparam int DIGIT_IDX_W = 4;
    localparam int SLICE_BITS  = 4;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [CHAR_W-1:0]    t_char;

    localparam t_cfg_idx CFG_RADIX      = 2'd0;
    localparam t_cfg_idx CFG_ALPHA_LOW  = 2'd1;
    localparam t_cfg_idx CFG_ALPHA_HIGH = 2'd2;

    localparam logic [RADIX_REG_W-1:0] RADIX_RESET      = 5'd10;
    localparam logic [RADIX_REG_W-1:0] RADIX_MIN        = 5'd2;
    localparam logic [CFG_DATA_W-1:0]  ALPHA_LOW_RESET  = 64'h3736353433323130;
    localparam logic [CFG_DATA_W-1:0]  ALPHA_HIGH_RESET = 64'h6665646362613938;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    function automatic t_char char_of(input logic [ALPHA_BITS-1:0] alpha,
                                      input logic [DIGIT_IDX_W-1:0] digit);
        return alpha[{digit, 3'b000} +: CHAR_W];
    endfunction

endpackage

FILE: rtl/core/rdc_divider.sv
`timescale 1ns / 1ps
`include "radix_digit_converter_unit_assert.svh"

module rdc_divider import rdc_pkg::*; #(
    parameter int VALUE_BITS = 64,
    parameter int DIGIT_W    = 4,
    parameter int RADIX_W    = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_operand,
    input  logic [RADIX_W-1:0]    i_radix,
    output logic [VALUE_BITS-1:0] o_quotient,
    output logic [DIGIT_W-1:0]    o_remainder,
    output t_div_status           o_status
);

    localparam int STEPS  = (VALUE_BITS + SLICE_BITS - 1) / SLICE_BITS;
    localparam int PAD_W  = STEPS * SLICE_BITS;
    localparam int STEP_W = $clog2(STEPS);

    logic [PAD_W-1:0]      r_work;
    logic [PAD_W-1:0]      n_work;
    logic [DIGIT_W-1:0]    r_rem;
    logic [DIGIT_W-1:0]    n_rem;
    logic [STEP_W-1:0]     r_step;
    logic                  r_busy;
    logic                  r_done;
    logic [DIGIT_W:0]      partial;
    logic [DIGIT_W:0]      radix_ext;
    logic [SLICE_BITS-1:0] q_bits;

    assign radix_ext = (DIGIT_W + 1)'(i_radix);

    // Restoring division, SLICE_BITS dividend bits per cycle, MSB first.
    always_comb begin
        n_rem   = r_rem;
        q_bits  = '0;
        partial = '0;
        for (int b = 0; b < SLICE_BITS; b++) begin
            partial = {n_rem, r_work[PAD_W-1-b]};
            if (partial >= radix_ext) begin
                n_rem = DIGIT_W'(partial - radix_ext);
                q_bits[SLICE_BITS-1-b] = 1'b1;
            end else begin
                n_rem = DIGIT_W'(partial);
            end
        end
        n_work = {r_work[PAD_W-SLICE_BITS-1:0], q_bits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == STEP_W'(STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= PAD_W'(i_operand);
            r_rem  <= '0;
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    assign o_quotient    = r_work[VALUE_BITS-1:0];
    assign o_remainder   = r_rem;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

    `RDC_ASSERT_NEXT(a_start_runs, i_clk, i_rst_n, i_start, r_busy && !r_done, "divider did not start")
    `RDC_ASSERT_NEXT(a_last_step_done, i_clk, i_rst_n, r_busy && !i_start && r_step == STEP_W'(STEPS - 1), r_done, "divider missed done")
    `RDC_ASSERT_IMP(a_rem_range, i_clk, i_rst_n, r_done, (DIGIT_W + 1)'(r_rem) < radix_ext, "remainder not below radix")

endmodule

FILE: rtl/core/rdc_digit_mem.sv
`timescale 1ns / 1ps

module rdc_digit_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/radix_digit_converter_unit.sv
// A number is accepted only while idle (busy low); a new one is not taken until its digits
// have all been read out. Each digit comes from the shared divider, which is run once per digit
// and retires 4 dividend bits per cycle.
// Digits then leave one per cycle on o_digit_valid; the receiver cannot stall.
// Reset (i_rst_n low, synchronous): idle, radix 10, alphabet "0123456789abcdef".
`timescale 1ns / 1ps
`include "radix_digit_converter_unit_assert.svh"

module radix_digit_converter_unit import rdc_pkg::*; #(
    parameter int VALUE_BITS = 64,
    parameter int MAX_RADIX  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic [NUMBER_W-1:0]   i_number,
    output logic                  busy,
    output logic                  o_digit_valid,
    output logic [CHAR_W-1:0]     o_digit_char,
    output logic                  o_last_digit,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DIGIT_W = $clog2(MAX_RADIX);
    localparam int RADIX_W = $clog2(MAX_RADIX + 1);
    localparam int ADDR_W  = $clog2(VALUE_BITS);
    localparam int CNT_W   = $clog2(VALUE_BITS + 1);

    t_state                  r_state;
    t_state                  n_state;
    logic [RADIX_REG_W-1:0]  r_radix;
    logic [CFG_DATA_W-1:0]   r_alpha_low;
    logic [CFG_DATA_W-1:0]   r_alpha_high;
    logic [RADIX_W-1:0]      eff_radix;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic [ADDR_W-1:0]       r_rd_ptr;
    logic [ADDR_W-1:0]       n_rd_ptr;
    logic                    r_out_valid;
    logic                    r_out_last;
    logic                    div_start;
    logic [VALUE_BITS-1:0]   div_operand;
    logic [VALUE_BITS-1:0]   div_quotient;
    logic [DIGIT_W-1:0]      div_rem;
    t_div_status             div_status;
    logic                    quo_zero;
    logic                    mem_we;
    logic                    mem_re;
    logic [DIGIT_W-1:0]      mem_rdata;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix      <= RADIX_RESET;
            r_alpha_low  <= ALPHA_LOW_RESET;
            r_alpha_high <= ALPHA_HIGH_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RADIX:      r_radix      <= i_cfg_data[RADIX_REG_W-1:0];
                CFG_ALPHA_LOW:  r_alpha_low  <= i_cfg_data;
                CFG_ALPHA_HIGH: r_alpha_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Clamp radix into 2..MAX_RADIX
    always_comb begin
        if (r_radix < RADIX_MIN) begin
            eff_radix = RADIX_W'(RADIX_MIN);
        end else if (r_radix > RADIX_REG_W'(MAX_RADIX)) begin
            eff_radix = RADIX_W'(MAX_RADIX);
        end else begin
            eff_radix = RADIX_W'(r_radix);
        end
    end

    assign quo_zero = (div_quotient == '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_status.done && quo_zero) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (r_rd_ptr == '0) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        div_start   = 1'b0;
        div_operand = div_quotient;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        n_count     = r_count;
        n_rd_ptr    = r_rd_ptr;
        case (r_state)
            ST_IDLE: begin
                div_operand = i_number[VALUE_BITS-1:0];
                if (start) begin
                    div_start = 1'b1;
                    n_count   = '0;
                end
            end
            ST_DIVIDE: begin
                if (div_status.done) begin
                    mem_we  = 1'b1;
                    n_count = r_count + 1'b1;
                    // store the digit, then either divide the quotient again or read back
                    if (quo_zero) begin
                        n_rd_ptr = r_count[ADDR_W-1:0];
                    end else begin
                        div_start = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                mem_re   = 1'b1;
                n_rd_ptr = r_rd_ptr - 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rd_ptr    <= '0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_ptr    <= n_rd_ptr;
            r_out_valid <= mem_re;
            r_out_last  <= mem_re && (r_rd_ptr == '0);
        end
    end

    rdc_divider #(
        .VALUE_BITS (VALUE_BITS),
        .DIGIT_W    (DIGIT_W),
        .RADIX_W    (RADIX_W)
    ) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_operand   (div_operand),
        .i_radix     (eff_radix),
        .o_quotient  (div_quotient),
        .o_remainder (div_rem),
        .o_status    (div_status)
    );

    rdc_digit_mem #(
        .DEPTH  (VALUE_BITS),
        .ADDR_W (ADDR_W),
        .DATA_W (DIGIT_W)
    ) u_digit_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (div_rem),
        .i_re    (mem_re),
        .i_raddr (r_rd_ptr),
        .o_rdata (mem_rdata)
    );

    assign busy          = (r_state != ST_IDLE);
    assign o_digit_valid = r_out_valid;
    assign o_last_digit  = r_out_last;
    assign o_digit_char  = char_of({r_alpha_high, r_alpha_low}, DIGIT_IDX_W'(mem_rdata));

    `RDC_ASSERT_NEXT(a_accept_divide, i_clk, i_rst_n, start && !busy,
        r_state == ST_DIVIDE, "accepted word did not start division")
    `RDC_ASSERT_NEXT(a_emit_strobe, i_clk, i_rst_n, r_state == ST_EMIT,
        o_digit_valid, "read-back without strobe")
    `RDC_ASSERT_IMP(a_last_idle, i_clk, i_rst_n, o_digit_valid && o_last_digit,
        r_state == ST_IDLE, "last digit while still busy")
    `RDC_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, r_state == ST_DIVIDE,
        r_count < CNT_W'(VALUE_BITS), "digit count overflow")

endmodule

FILE: verif/radix_digit_converter_unit_test.sv
`timescale 1ns / 1ps

module radix_digit_converter_unit_test;
    import rdc_pkg::*;

    localparam int VALUE_BITS = 64;
    localparam int MAX_RADIX = 16;
    localparam int QUIET_LIMIT = 5000;
    localparam int RANDOM_PHASES = 7;
    localparam int ITEMS_PER_PHASE = 36;
    localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_BITS);
    localparam logic [63:0] ALL_ONES = {64{1'b1}};
    localparam logic [63:0] UPPER_HIGH = 64'h4645444342413938;
    // index 3 is not decoded by the block
    localparam t_cfg_idx CFG_UNUSED = 2'd3;

    typedef struct packed {
        t_char ch;
        logic  last;
    } t_digit_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic [NUMBER_W-1:0]   i_number = '0;
    logic                  busy;
    logic                  o_digit_valid;
    logic [CHAR_W-1:0]     o_digit_char;
    logic                  o_last_digit;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // shadow copy of the configuration registers
    logic [RADIX_REG_W-1:0] cfg_radix = RADIX_RESET;
    logic [63:0]            cfg_alpha_low = ALPHA_LOW_RESET;
    logic [63:0]            cfg_alpha_high = ALPHA_HIGH_RESET;

    logic [63:0]  pending_numbers[$];
    t_digit_word  expected_digits[$];
    int           items_queued = 0;
    int           items_taken = 0;
    int           digits_seen = 0;
    int           cfg_writes = 0;
    int           errors = 0;
    int           gap_left = 0;
    bit           bursts_on = 1'b1;
    int           quiet_cycles = 0;
    int           last_activity = 0;

    radix_digit_converter_unit #(
        .VALUE_BITS(VALUE_BITS),
        .MAX_RADIX (MAX_RADIX)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_number     (i_number),
        .busy         (busy),
        .o_digit_valid(o_digit_valid),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Split the value into digits of the clamped radix, most significant first.
    function automatic void predict_digits(input logic [63:0] value);
        logic [4:0]  base;
        logic [63:0] rest;
        logic [3:0]  slot_digits [64];
        int          count;
        int          d;
        t_digit_word w;
        base = cfg_radix;
        if (base < 5'd2) base = 5'd2;
        if (base > 5'(MAX_RADIX)) base = 5'(MAX_RADIX);
        rest = value & VALUE_MASK;
        count = 0;
        do begin
            slot_digits[count] = 4'(rest % base);
            rest = rest / base;
            count++;
        end while (rest != 0 && count < 64);
        for (int k = 0; k < count; k++) begin
            d = int'(slot_digits[count - 1 - k]);
            w.ch = (d < 8) ? cfg_alpha_low[8*d +: 8] : cfg_alpha_high[8*(d-8) +: 8];
            w.last = (k + 1 == count);
            expected_digits.push_back(w);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                predict_digits(i_number);
                items_taken++;
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    // hold off while the block is free so the gap is visible
                    start <= 1'b0;
                    if (!busy) gap_left--;
                end else if (pending_numbers.size() > 0) begin
                    start <= 1'b1;
                    i_number <= pending_numbers.pop_front();
                    if (bursts_on && $urandom_range(0, 2) == 0)
                        gap_left = $urandom_range(1, 4);
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : digit_check
        t_digit_word want;
        if (i_rst_n && o_digit_valid) begin
            digits_seen++;
            if (expected_digits.size() == 0) begin
                errors++;
                $display("%0t: unexpected digit: expected none, actual char %h last %b",
                         $time, o_digit_char, o_last_digit);
            end else begin
                want = expected_digits.pop_front();
                if (want.ch !== o_digit_char) begin
                    errors++;
                    $display("%0t: digit_char mismatch: expected %h, actual %h",
                             $time, want.ch, o_digit_char);
                end
                if (want.last !== o_last_digit) begin
                    errors++;
                    $display("%0t: last_digit mismatch: expected %b, actual %b",
                             $time, want.last, o_last_digit);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (items_taken + digits_seen + cfg_writes != last_activity) begin
                last_activity = items_taken + digits_seen + cfg_writes;
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic queue_number(input logic [63:0] value);
        pending_numbers.push_back(value);
        items_queued++;
    endtask

    // Wait until every number is taken, every digit has come and the block is idle.
    task automatic drain();
        while (items_taken != items_queued) @(posedge i_clk);
        while (expected_digits.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_register(input t_cfg_idx idx, input logic [63:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            CFG_RADIX:      cfg_radix = data[RADIX_REG_W-1:0];
            CFG_ALPHA_LOW:  cfg_alpha_low = data;
            CFG_ALPHA_HIGH: cfg_alpha_high = data;
            default: ;
        endcase
    endtask

    function automatic logic [63:0] random_number();
        logic [63:0] v;
        int          k;
        v = {$urandom, $urandom};
        k = $urandom_range(0, 63);
        case ($urandom_range(0, 4))
            0:       return v & 64'hFF;
            1:       return v >> k;
            2:       return (64'd1 << k) - {63'd0, $urandom_range(0, 1) == 1};
            default: return v;
        endcase
    endfunction

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: decimal with the default alphabet
        queue_number(64'd0);
        queue_number(64'd1);
        queue_number(64'd9);
        queue_number(64'd10);
        queue_number(64'd99);
        queue_number(64'd100);
        queue_number(64'd12345678901234567890);
        queue_number(ALL_ONES);
        queue_number(64'h8000_0000_0000_0000);
        drain();

        // binary with arbitrary characters; all ones gives the full 64 digits
        program_register(CFG_RADIX, 64'd2);
        program_register(CFG_ALPHA_LOW, {$urandom, $urandom});
        program_register(CFG_ALPHA_HIGH, {$urandom, $urandom});
        queue_number(64'd0);
        queue_number(64'd1);
        queue_number(ALL_ONES);
        queue_number(64'h5555_5555_5555_5555);
        queue_number(64'h8000_0000_0000_0000);
        drain();

        program_register(CFG_RADIX, 64'd16);
        program_register(CFG_ALPHA_LOW, ALPHA_LOW_RESET);
        program_register(CFG_ALPHA_HIGH, UPPER_HIGH);
        queue_number(64'd0);
        queue_number(64'd15);
        queue_number(64'd16);
        queue_number(64'hFEDC_BA98_7654_3210);
        queue_number(ALL_ONES);
        drain();

        // out-of-range radix values clamp to the nearest legal base
        program_register(CFG_UNUSED, {$urandom, $urandom});
        program_register(CFG_RADIX, 64'd0);
        queue_number(64'd2);
        queue_number(64'd3);
        drain();
        program_register(CFG_RADIX, 64'd1);
        queue_number(64'd5);
        drain();
        program_register(CFG_RADIX, {59'h7FF_FFFF_FFFF_FFFF, 5'd31});
        queue_number(ALL_ONES);
        queue_number(64'd255);
        drain();
        program_register(CFG_RADIX, 64'd17);
        queue_number(64'd256);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p >= RANDOM_PHASES - 2) bursts_on = 1'b0;
            program_register(CFG_RADIX, {$urandom, $urandom});
            if ($urandom_range(0, 1) == 1) begin
                program_register(CFG_ALPHA_LOW, {$urandom, $urandom});
                program_register(CFG_ALPHA_HIGH, {$urandom, $urandom});
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++) queue_number(random_number());
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (expected_digits.size() != 0) begin
            errors++;
            $display("%0t: %0d digits never arrived", $time, expected_digits.size());
        end
        $display("Converted %0d numbers into %0d checked digits, %0d mismatches.",
                 items_taken, digits_seen, errors);
        $display("Register writes: %0d, radix settings 0..31 with clamping and custom alphabets.",
                 cfg_writes);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/rdc_pkg.sv
rtl/core/rdc_divider.sv
rtl/core/rdc_digit_mem.sv
rtl/core/radix_digit_converter_unit.sv
verif/radix_digit_converter_unit_test.sv
